[rtl/art_pkg.sv]
package art_pkg;

    // fixed item field widths
    localparam int OPCODE_BITS      = 2;
    localparam int FIELD_BITS       = 32;
    localparam int COUNT_FIELD_BITS = 5;

    // packed stream widths
    localparam int IN_DATA_BITS  = 2 * FIELD_BITS;
    localparam int IN_USER_BITS  = 8;
    localparam int OUT_DATA_BITS = 8;

    // defaults for the top level parameters
    localparam int DEF_MAX_REGIONS = 16;
    localparam int DEF_ADDR_BITS   = 32;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_AVAIL  = 2'd3
    } t_op;

endpackage

[rtl/art_cell.sv]
module art_cell #(
    parameter int ADDR_BITS = art_pkg::DEF_ADDR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_shift,
    input  logic [ADDR_BITS-1:0] i_base,
    input  logic [ADDR_BITS-1:0] i_size,
    output logic [ADDR_BITS-1:0] o_base,
    output logic [ADDR_BITS-1:0] o_size,
    input  logic                 i_query,
    input  logic                 i_lookup,
    input  logic                 i_active,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [ADDR_BITS-1:0] i_len,
    output logic                 o_hit
);

    logic [ADDR_BITS-1:0] r_base;
    logic [ADDR_BITS-1:0] r_size;
    logic                 r_hit;
    logic                 n_hit;

    logic [ADDR_BITS:0] w_region_end;
    logic [ADDR_BITS:0] w_range_end;
    logic               w_holds;
    logic               w_overlap;

    // sums one bit wider so they never wrap
    assign w_region_end = {1'b0, r_base} + {1'b0, r_size};
    assign w_range_end  = {1'b0, i_addr} + {1'b0, i_len};

    assign w_holds   = (i_addr >= r_base) && (w_region_end > {1'b0, i_addr});
    assign w_overlap = !((w_range_end <= {1'b0, r_base}) ||
                         (w_region_end <= {1'b0, i_addr}));

    always_comb begin
        n_hit = i_active && (i_lookup ? w_holds : w_overlap);
    end

    // region moves one cell down the row on every append
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_base <= i_base;
            r_size <= i_size;
        end
        if (i_query) begin
            r_hit <= n_hit;
        end
    end

    assign o_base = r_base;
    assign o_size = r_size;
    assign o_hit  = r_hit;

endmodule

[rtl/address_region_table.sv]
// address region table: holds up to MAX_REGIONS regions, each a base and a
// size, in a row of cells. an add item that finds room shifts every held
// region one cell down and writes the new one into cell 0, so the first
// region_count cells are always the live ones. clear only resets the count.
// lookup and availability items are compared against all cells at once:
// each cell tests its own region (half-open, base inclusive, ends formed
// one bit wider than an address) and registers a hit bit, and the hit
// bits are then ored into the output register. every item gets exactly one
// result carrying result_flag and the region count after the item.
// timing: an item is accepted only while no earlier item is at work; its
// hits are registered in the cells, then reduced into the output register
// once that register is free, and the next item is accepted as soon as the
// result has moved into the output register, even if that result is still
// waiting on i_m_tready.
module address_region_table #(
    parameter int MAX_REGIONS = art_pkg::DEF_MAX_REGIONS,
    parameter int ADDR_BITS   = art_pkg::DEF_ADDR_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [31:0] address, [63:32] length
    input  logic [art_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    // [1:0] opcode, [7:2] zero
    input  logic [art_pkg::IN_USER_BITS-1:0]   i_s_tuser,
    // result item stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] result_flag, [5:1] region_count, [7:6] zero
    output logic [art_pkg::OUT_DATA_BITS-1:0]  o_m_tdata
);

    import art_pkg::*;

    localparam int CW = $clog2(MAX_REGIONS + 1);

    // control
    logic          r_busy;
    logic          n_busy;
    logic          r_out_valid;
    logic          n_out_valid;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // item held while its hits are reduced
    t_op           r_op;
    logic          r_add_ok;
    logic          n_flag;

    // output register
    logic                   r_flag;
    logic [CW-1:0]          r_out_count;

    // handshake terms
    logic w_accept;
    logic w_out_free;
    logic w_load;

    // decoded item
    t_op                  w_op;
    logic [ADDR_BITS-1:0] w_addr;
    logic [ADDR_BITS-1:0] w_len;
    logic                 w_full;
    logic                 w_shift;
    logic                 w_lookup;

    // row of cells
    logic [ADDR_BITS-1:0] w_base [0:MAX_REGIONS-1];
    logic [ADDR_BITS-1:0] w_size [0:MAX_REGIONS-1];
    logic [MAX_REGIONS-1:0] w_hit;

    assign w_op   = t_op'(i_s_tuser[OPCODE_BITS-1:0]);
    // address and length are cut or zero-extended to the address width
    assign w_addr = ADDR_BITS'(i_s_tdata[FIELD_BITS-1:0]);
    assign w_len  = ADDR_BITS'(i_s_tdata[2*FIELD_BITS-1:FIELD_BITS]);

    assign w_full     = (r_count >= CW'(MAX_REGIONS));
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && !r_busy;
    assign w_load     = r_busy && w_out_free;
    assign w_shift    = w_accept && (w_op == OP_ADD) && !w_full;
    assign w_lookup   = (w_op == OP_LOOKUP);

    genvar g;
    generate
        for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
            logic [ADDR_BITS-1:0] w_base_in;
            logic [ADDR_BITS-1:0] w_size_in;

            if (g == 0) begin : g_head
                // new region enters at the head of the row
                assign w_base_in = w_addr;
                assign w_size_in = w_len;
            end else begin : g_link
                assign w_base_in = w_base[g-1];
                assign w_size_in = w_size[g-1];
            end

            art_cell #(
                .ADDR_BITS (ADDR_BITS)
            ) u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_shift),
                .i_base   (w_base_in),
                .i_size   (w_size_in),
                .o_base   (w_base[g]),
                .o_size   (w_size[g]),
                .i_query  (w_accept),
                .i_lookup (w_lookup),
                .i_active (CW'(g) < r_count),
                .i_addr   (w_addr),
                .i_len    (w_len),
                .o_hit    (w_hit[g])
            );
        end
    endgenerate

    // next state of the control registers
    always_comb begin
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_count     = r_count;
        if (w_accept) begin
            n_busy = 1'b1;
            case (w_op)
                OP_CLEAR: begin
                    n_count = '0;
                end
                OP_ADD: begin
                    if (!w_full) begin
                        n_count = r_count + CW'(1);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end else if (w_load) begin
            n_busy = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // result flag from the held item: the add outcome or the registered cell hits
    always_comb begin
        case (r_op)
            OP_CLEAR:  n_flag = 1'b0;
            OP_ADD:    n_flag = r_add_ok;
            OP_LOOKUP: n_flag = |w_hit;
            OP_AVAIL:  n_flag = !(|w_hit);
            default:   n_flag = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= w_op;
            r_add_ok <= !w_full;
        end
        if (w_load) begin
            r_flag      <= n_flag;
            // count is already updated when the result is loaded
            r_out_count <= r_count;
        end
    end

    assign o_s_tready = !r_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_BITS - 1 - COUNT_FIELD_BITS){1'b0}},
                         COUNT_FIELD_BITS'(r_out_count), r_flag};

endmodule

[rtl/art_checker.sv]
module art_checker #(
    parameter int MAX_REGIONS = art_pkg::DEF_MAX_REGIONS
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [art_pkg::IN_USER_BITS-1:0]  i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [art_pkg::OUT_DATA_BITS-1:0] o_m_tdata
);

    import art_pkg::*;

    logic w_in_acc;
    logic w_clear;

    assign w_in_acc = i_s_tvalid && o_s_tready;
    assign w_clear  = (i_s_tuser[OPCODE_BITS-1:0] == OP_CLEAR);

    // one item at a time: no second accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_s_tready)
        else $error("item accepted while the previous one is still at work");

    // a clear with a free output then shows flag 0 and count 0 in the output register
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_clear && (!o_m_tvalid || i_m_tready))
        |=> ##1 (o_m_tvalid && (o_m_tdata[COUNT_FIELD_BITS:0] == '0)))
        else $error("clear did not give an empty result");

    // reported count never exceeds the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (int'(o_m_tdata[COUNT_FIELD_BITS:1]) <= MAX_REGIONS))
        else $error("region count above table depth");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind address_region_table art_checker #(
    .MAX_REGIONS (MAX_REGIONS)
) u_art_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
